@@ design/slss_pkg.sv @@
// Shared types and constants for the slew-limited step sequencer.
`default_nettype none

package slss_pkg;

  localparam int DEF_PHASE_COUNT = 8;
  localparam int DEF_FULL_SCALE  = 1023;

  localparam int LEVEL_W = 10;   // level_value, dac_code, step_size
  localparam int IDX_W   = 3;    // level_index, phase_index
  localparam int CFG_IDX_W = 1;

  localparam logic [LEVEL_W-1:0] STEP_SIZE_RST = LEVEL_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MODE = CFG_IDX_W'(1);

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [IDX_W-1:0]   level_index;
    logic [LEVEL_W-1:0] level_value;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] dac_code;
    logic [IDX_W-1:0]   phase_index;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] step_size;
    logic               mirror_mode;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/slew_limited_step_sequencer_top.sv @@
// Top level of the slew-limited step sequencer: handshakes, config and result register.
`default_nettype none

// Step sequencer with slew limiting. A load item writes one entry of the level
// table and gives no result; a tick item gives the current value and phase, then
// ramps the value toward the active phase's level by step_size, snapping to the
// level and advancing the phase when it arrives. Every item is done by the update
// logic in front of the state registers, so one item is taken per clock while
// in_ready is high; a tick result then sits in the output register, and the next
// item is taken in the same cycle that register is emptied. Configuration writes
// are always taken (cfg_ready is tied high) and act on the next item.
module slew_limited_step_sequencer_top
  import slss_pkg::*;
#(
  parameter int PHASE_COUNT = DEF_PHASE_COUNT,
  parameter int FULL_SCALE  = DEF_FULL_SCALE
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEVEL_W-1:0]   cfg_data
);

  cfg_t      cfg_r, cfg_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  out_item_t core_result;
  logic      accept, tick_en, load_en;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign tick_en   = accept && (in_item.func == FUNC_TICK);
  assign load_en   = accept && (in_item.func == FUNC_LOAD);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:   cfg_nxt.step_size   = cfg_data;
        CFG_MIRROR_MODE: cfg_nxt.mirror_mode = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (tick_en) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = core_result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size   <= STEP_SIZE_RST;
      cfg_r.mirror_mode <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  slss_core #(
    .PHASE_COUNT (PHASE_COUNT),
    .FULL_SCALE  (FULL_SCALE)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_en (load_en),
    .tick_en (tick_en),
    .item    (in_item),
    .cfg     (cfg_r),
    .result  (core_result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ design/slss_core.sv @@
// Sequencer state: level table, current value, phase and ramp update.
`default_nettype none

module slss_core
  import slss_pkg::*;
#(
  parameter int PHASE_COUNT = DEF_PHASE_COUNT,
  parameter int FULL_SCALE  = DEF_FULL_SCALE
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load_en,
  input  wire logic      tick_en,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      result
);

  localparam int FS_W  = $clog2(FULL_SCALE + 1);
  localparam int CUR_W = (FS_W > LEVEL_W) ? FS_W : LEVEL_W;
  localparam int PH_W  = $clog2(PHASE_COUNT);
  localparam int IXC_W = ((PH_W > IDX_W) ? PH_W : IDX_W) + 1;

  localparam logic [PH_W-1:0]  LAST_PH  = PH_W'(PHASE_COUNT - 1);
  localparam logic [PH_W-1:0]  TURN_PH  = PH_W'(PHASE_COUNT - 2);
  localparam logic [PH_W-1:0]  FIRST_PH = PH_W'(0);
  localparam logic [PH_W-1:0]  ONE_PH   = PH_W'(1);
  localparam logic [CUR_W:0]   FS_EXT   = (CUR_W + 1)'(FULL_SCALE);
  localparam logic [IXC_W-1:0] PC_EXT   = IXC_W'(PHASE_COUNT);

  logic [LEVEL_W-1:0] levels_r [PHASE_COUNT];
  logic [LEVEL_W-1:0] active_level_r, active_level_nxt;
  logic [CUR_W-1:0]   cur_r, cur_nxt;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic               ramp_down_r, ramp_down_nxt;
  logic               backward_r, backward_nxt;

  logic [IXC_W-1:0]   load_idx_ext;
  logic [PH_W-1:0]    load_idx;
  logic               load_ok;
  logic [IXC_W-1:0]   phase_ext;
  logic [CUR_W:0]     cur_ext, step_ext, lvl_ext, sum, diff;
  logic [PH_W-1:0]    adv_phase;
  logic               adv_backward;
  logic [LEVEL_W-1:0] adv_level;
  logic               move;

  assign load_idx_ext = IXC_W'(item.level_index);
  assign load_idx     = load_idx_ext[PH_W-1:0];
  assign load_ok      = load_idx_ext < PC_EXT;

  assign cur_ext  = (CUR_W + 1)'(cur_r);
  assign step_ext = (CUR_W + 1)'(cfg.step_size);
  assign lvl_ext  = (CUR_W + 1)'(active_level_r);
  assign sum      = cur_ext + step_ext;
  assign diff     = cur_ext - step_ext;

  // phase advance: wrap, or ping-pong when mirrored
  always_comb begin
    adv_backward = backward_r;
    if (cfg.mirror_mode) begin
      if (backward_r) begin
        if (phase_r == FIRST_PH) begin
          adv_phase    = ONE_PH;
          adv_backward = 1'b0;
        end else begin
          adv_phase = phase_r - ONE_PH;
        end
      end else if (phase_r >= LAST_PH) begin
        adv_phase    = TURN_PH;
        adv_backward = 1'b1;
      end else begin
        adv_phase = phase_r + ONE_PH;
      end
    end else if (phase_r >= LAST_PH) begin
      adv_phase = FIRST_PH;
    end else begin
      adv_phase = phase_r + ONE_PH;
    end
  end

  assign adv_level = levels_r[adv_phase];

  always_comb begin
    if (ramp_down_r) begin
      move = (cur_ext > lvl_ext) && (cur_ext >= step_ext);
    end else begin
      move = (cur_ext < lvl_ext) && (sum < FS_EXT);
    end
  end

  always_comb begin
    cur_nxt          = cur_r;
    phase_nxt        = phase_r;
    ramp_down_nxt    = ramp_down_r;
    backward_nxt     = backward_r;
    active_level_nxt = active_level_r;
    if (tick_en) begin
      if (move) begin
        cur_nxt = ramp_down_r ? diff[CUR_W-1:0] : sum[CUR_W-1:0];
      end else begin
        // snap to the level and move on to the next phase
        cur_nxt          = CUR_W'(active_level_r);
        phase_nxt        = adv_phase;
        backward_nxt     = adv_backward;
        active_level_nxt = adv_level;
        ramp_down_nxt    = active_level_r > adv_level;
      end
    end else if (load_en && load_ok && (load_idx == phase_r)) begin
      active_level_nxt = item.level_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PHASE_COUNT; i++) begin
        levels_r[i] <= '0;
      end
      active_level_r <= '0;
      cur_r          <= '0;
      phase_r        <= '0;
      ramp_down_r    <= 1'b0;
      backward_r     <= 1'b0;
    end else begin
      if (load_en && load_ok) begin
        levels_r[load_idx] <= item.level_value;
      end
      active_level_r <= active_level_nxt;
      cur_r          <= cur_nxt;
      phase_r        <= phase_nxt;
      ramp_down_r    <= ramp_down_nxt;
      backward_r     <= backward_nxt;
    end
  end

  assign phase_ext          = IXC_W'(phase_r);
  assign result.dac_code    = cur_r[LEVEL_W-1:0];
  assign result.phase_index = phase_ext[IDX_W-1:0];

endmodule

`default_nettype wire

@@ dv/slew_limited_step_sequencer_top_test.sv @@
// Self-checking testbench for the slew-limited step sequencer top level.
module slew_limited_step_sequencer_top_test;
  import slss_pkg::*;

  localparam int PHASES         = DEF_PHASE_COUNT;
  localparam int FULL           = DEF_FULL_SCALE;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEG_SEGMENTS   = 4;
  localparam int SEG_ITEMS      = 70;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_data;

  slew_limited_step_sequencer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sequencer state as the testbench sees it
  logic [LEVEL_W-1:0] lvl_table [PHASES];
  int unsigned        cur_val;
  int unsigned        phase;
  bit                 going_down;
  bit                 going_back;
  int unsigned        step_sz;
  bit                 mirror_on;

  out_item_t   expected_dac_q [$];
  int unsigned error_count;
  int          sender_idle_pct;
  int          receiver_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
    error_count++;
  endtask

  task automatic snap_to_level(input int unsigned lvl);
    cur_val = lvl;
    if (mirror_on) begin
      if (going_back) begin
        if (phase == 0) begin
          phase      = 1;
          going_back = 1'b0;
        end else begin
          phase--;
        end
      end else if (phase >= PHASES - 1) begin
        phase      = PHASES - 2;
        going_back = 1'b1;
      end else begin
        phase++;
      end
    end else begin
      phase = (phase + 1) % PHASES;
    end
    going_down = cur_val > lvl_table[phase];
  endtask

  task automatic predict_dac_step(input in_item_t it);
    int unsigned lvl;
    out_item_t   res;
    if (it.func == FUNC_LOAD) begin
      lvl_table[it.level_index] = it.level_value;
      return;
    end
    res.dac_code    = LEVEL_W'(cur_val);
    res.phase_index = IDX_W'(phase);
    expected_dac_q.push_back(res);
    lvl = lvl_table[phase];
    if (going_down) begin
      if (cur_val > lvl && cur_val >= step_sz) cur_val -= step_sz;
      else snap_to_level(lvl);
    end else if (cur_val < lvl && cur_val + step_sz < FULL) begin
      // may overshoot the level; the next tick snaps back
      cur_val += step_sz;
    end else begin
      snap_to_level(lvl);
    end
  endtask

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predict_dac_step(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it.func        = FUNC_TICK;
    it.level_index = IDX_W'($urandom_range(0, 7));
    it.level_value = LEVEL_W'($urandom_range(0, 1023));
    send_item(it);
  endtask

  task automatic send_load(input int unsigned idx, input int unsigned val);
    in_item_t it;
    it.func        = FUNC_LOAD;
    it.level_index = IDX_W'(idx);
    it.level_value = LEVEL_W'(val);
    send_item(it);
  endtask

  // sender drops valid and holds off until the output side has drained
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_dac_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
    wait_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_STEP_SIZE) step_sz = data;
    else mirror_on = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_dac_q.size() == 0) begin
        report_mismatch("result with nothing pending, dac_code", 0, out_item.dac_code);
      end else begin
        want = expected_dac_q.pop_front();
        if (out_item.dac_code !== want.dac_code)
          report_mismatch("dac_code", want.dac_code, out_item.dac_code);
        if (out_item.phase_index !== want.phase_index)
          report_mismatch("phase_index", want.phase_index, out_item.phase_index);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // zero table after reset: every tick snaps and the phase walks forward
  task automatic test_reset_state();
    repeat (3) send_tick();
  endtask

  // full-scale levels with the largest step: ramp refused, snap, then full drop
  task automatic test_full_scale_levels();
    write_cfg(CFG_STEP_SIZE, LEVEL_W'(1023));
    send_load(3, 1023);
    send_load(4, 1023);
    repeat (3) send_tick();
  endtask

  // step of zero leaves the ramp stuck; the later load to entry 7 does not free it
  task automatic test_zero_step();
    write_cfg(CFG_STEP_SIZE, LEVEL_W'(0));
    send_load(5, 600);
    send_load(7, 1023);
    repeat (5) send_tick();
    send_load(7, 600);
    send_tick();
  endtask

  // ping-pong: walk up to the last phase and turn back
  task automatic test_mirror_turns();
    write_cfg(CFG_STEP_SIZE, LEVEL_W'(1023));
    write_cfg(CFG_MIRROR_MODE, LEVEL_W'(1));
    repeat (8) send_tick();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    in_item_t it;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int seg = 0; seg < SEG_SEGMENTS; seg++) begin
      case ($urandom_range(0, 4))
        0:       write_cfg(CFG_STEP_SIZE, LEVEL_W'(0));
        1:       write_cfg(CFG_STEP_SIZE, LEVEL_W'(1));
        2:       write_cfg(CFG_STEP_SIZE, LEVEL_W'(1023));
        3:       write_cfg(CFG_STEP_SIZE, LEVEL_W'($urandom_range(2, 64)));
        default: write_cfg(CFG_STEP_SIZE, LEVEL_W'($urandom_range(0, 1023)));
      endcase
      // upper data bits are don't-care for the mode register
      write_cfg(CFG_MIRROR_MODE, LEVEL_W'($urandom_range(0, 1023)));
      for (int i = 0; i < PHASES; i++) send_load(i, $urandom_range(0, 1023));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (n == SEG_ITEMS / 2) wait_results();
        it.func        = ($urandom_range(0, 99) < 25) ? FUNC_LOAD : FUNC_TICK;
        it.level_index = IDX_W'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
          0:       it.level_value = '0;
          1:       it.level_value = LEVEL_W'(1023);
          default: it.level_value = LEVEL_W'($urandom_range(0, 1023));
        endcase
        send_item(it);
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_item            = '0;
    out_ready          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    error_count        = 0;
    for (int i = 0; i < PHASES; i++) lvl_table[i] = '0;
    cur_val    = 0;
    phase      = 0;
    going_down = 1'b0;
    going_back = 1'b0;
    step_sz    = STEP_SIZE_RST;
    mirror_on  = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_full_scale_levels();
    test_zero_step();
    test_mirror_turns();
    test_random_traffic(0, 0);
    test_random_traffic(83, 0);
    test_random_traffic(0, 83);
    test_random_traffic(12, 12);
    wait_results();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
